// File: src/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg: shared types for the look-at view matrix block
// Row codes, register indexes and the row record handed to the output stage.
// ----------------------------------------------------------------------------
package lav_pkg;

  // Byte address width of the configuration port: three registers at 0, 4, 8.
  localparam int APB_AW = 4;

  typedef enum logic [1:0] {
    ROW_RIGHT = 2'd0,
    ROW_UP    = 2'd1,
    ROW_FWD   = 2'd2
  } row_t;

  typedef enum logic [1:0] {
    REG_UP_X = 2'd0,
    REG_UP_Y = 2'd1,
    REG_UP_Z = 2'd2
  } reg_idx_t;

  // One matrix row, laid out as it leaves on the stream bus (cx lowest).
  typedef struct packed {
    logic [31:0] ofs;
    logic [31:0] cz;
    logic [31:0] cy;
    logic [31:0] cx;
  } row_data_t;

  typedef struct packed {
    logic            degen;
    row_data_t [2:0] rows;
  } view_t;

endpackage

// File: src/lav_sqrt.sv
// ----------------------------------------------------------------------------
// lav_sqrt: pipelined integer square root
// Floor square root of a 62-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module lav_sqrt
  import lav_pkg::*;
#(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [61:0]   rad,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [30:0]   root,
  output logic [PW-1:0] out_pay
);

  localparam int N = 31;

  logic          vld    [0:N-1];
  logic [61:0]   rad_q  [0:N-1];
  logic [31:0]   rem_q  [0:N-1];
  logic [30:0]   root_q [0:N-1];
  logic [PW-1:0] pay_q  [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic          v_i;
    logic [61:0]   rad_i;
    logic [31:0]   rem_i;
    logic [30:0]   root_i;
    logic [PW-1:0] pay_i;
    logic [33:0]   rem2;
    logic [33:0]   trial;
    logic [33:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign pay_i  = in_pay;
    end else begin : g_next
      assign v_i    = vld[k-1];
      assign rad_i  = rad_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign pay_i  = pay_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem2  = {rem_i, rad_i[61:60]};
    assign trial = {1'b0, root_i, 2'b01};
    assign diff  = rem2 - trial;
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= {rad_i[59:0], 2'b00};
        rem_q[k]  <= ge ? diff[31:0] : rem2[31:0];
        root_q[k] <= {root_i[29:0], ge};
        pay_q[k]  <= pay_i;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign root      = root_q[N-1];
  assign out_pay   = pay_q[N-1];

endmodule

// File: src/lav_div.sv
// ----------------------------------------------------------------------------
// lav_div: pipelined three-lane divider
// Computes (m << 30) / len for three numerators, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_div
  import lav_pkg::*;
#(
  parameter int PW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [30:0]      dsr,
  input  logic [2:0][29:0] m,
  input  logic [PW-1:0]    in_pay,
  output logic             out_valid,
  output logic [2:0][30:0] quot,
  output logic [PW-1:0]    out_pay
);

  localparam int N = 31;

  logic             vld    [0:N-1];
  logic [30:0]      dsr_q  [0:N-1];
  logic [2:0][30:0] rem_q  [0:N-1];
  logic [2:0][30:0] bits_q [0:N-1];
  logic [2:0][30:0] quot_q [0:N-1];
  logic [PW-1:0]    pay_q  [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic             v_i;
    logic [30:0]      dsr_i;
    logic [2:0][30:0] rem_i;
    logic [2:0][30:0] bits_i;
    logic [2:0][30:0] quot_i;
    logic [PW-1:0]    pay_i;
    logic [2:0][31:0] rem2;
    logic [2:0][31:0] diff;
    logic [2:0]       ge;

    if (k == 0) begin : g_first
      // The upper 29 quotient bits are always zero, so start part way in.
      assign v_i   = in_valid;
      assign dsr_i = dsr;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_i[i]  = {2'b00, m[i][29:1]};
        assign bits_i[i] = {m[i][0], 30'd0};
      end
      assign quot_i = '0;
      assign pay_i  = in_pay;
    end else begin : g_next
      assign v_i    = vld[k-1];
      assign dsr_i  = dsr_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign bits_i = bits_q[k-1];
      assign quot_i = quot_q[k-1];
      assign pay_i  = pay_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rem2[i] = {rem_i[i], bits_i[i][30]};
        diff[i] = rem2[i] - {1'b0, dsr_i};
        ge[i]   = (rem2[i] >= {1'b0, dsr_i});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dsr_q[k] <= dsr_i;
        pay_q[k] <= pay_i;
        for (int i = 0; i < 3; i++) begin
          rem_q[k][i]  <= ge[i] ? diff[i][30:0] : rem2[i][30:0];
          bits_q[k][i] <= {bits_i[i][29:0], 1'b0};
          quot_q[k][i] <= {quot_i[i][29:0], ge[i]};
        end
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quot      = quot_q[N-1];
  assign out_pay   = pay_q[N-1];

endmodule

// File: src/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm: pipelined vector normaliser
// Scales a three-component vector to a unit vector in Q2.30 and flags a
// zero vector. A side payload travels alongside with the same latency.
// ----------------------------------------------------------------------------
module lav_norm
  import lav_pkg::*;
#(
  parameter int IW = 33,
  parameter int SW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0][IW-1:0] v,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [2:0][31:0] u,
  output logic             out_ok,
  output logic [SW-1:0]    out_side
);

  localparam int BW  = $clog2(IW + 1);
  localparam int PW1 = SW + 4 + 90;
  localparam int PW2 = SW + 4;

  // Stage 1: magnitudes and signs.
  logic               s1_v;
  logic [2:0][IW-1:0] s1_mag;
  logic [2:0]         s1_sgn;
  logic [SW-1:0]      s1_side;
  // Stage 2: bit length of the largest magnitude.
  logic               s2_v;
  logic [2:0][IW-1:0] s2_mag;
  logic [2:0]         s2_sgn;
  logic [BW-1:0]      s2_bl;
  logic [SW-1:0]      s2_side;
  // Stage 3: magnitudes scaled so that the largest lies in [2^29, 2^30).
  logic               s3_v;
  logic [2:0][29:0]   s3_m;
  logic [2:0]         s3_sgn;
  logic               s3_ok;
  logic [SW-1:0]      s3_side;
  // Stage 4: squares.
  logic               s4_v;
  logic [2:0][59:0]   s4_sq;
  logic [2:0][29:0]   s4_m;
  logic [2:0]         s4_sgn;
  logic               s4_ok;
  logic [SW-1:0]      s4_side;
  // Stage 5: sum of squares.
  logic               s5_v;
  logic [61:0]        s5_sum;
  logic [2:0][29:0]   s5_m;
  logic [2:0]         s5_sgn;
  logic               s5_ok;
  logic [SW-1:0]      s5_side;

  logic [IW-1:0]      orv;
  logic [BW-1:0]      bl;
  logic [BW-1:0]      sh_r;
  logic [BW-1:0]      sh_l;
  logic [2:0][IW-1:0] m_r;
  logic [2:0][29:0]   m_l;

  logic               sq_v;
  logic [30:0]        sq_root;
  logic [PW1-1:0]     sq_pay;
  logic [SW-1:0]      sq_side;
  logic               sq_ok;
  logic [2:0]         sq_sgn;
  logic [2:0][29:0]   sq_m;

  logic               dv_v;
  logic [2:0][30:0]   dv_q;
  logic [PW2-1:0]     dv_pay;
  logic [SW-1:0]      dv_side;
  logic               dv_ok;
  logic [2:0]         dv_sgn;

  logic               o_v;
  logic [2:0][31:0]   o_u;
  logic               o_ok;
  logic [SW-1:0]      o_side;

  always_comb begin
    orv = s1_mag[0] | s1_mag[1] | s1_mag[2];
    bl  = '0;
    for (int j = 0; j < IW; j++) begin
      if (orv[j]) begin
        bl = BW'(j + 1);
      end
    end
  end

  assign sh_r = s2_bl - BW'(30);
  assign sh_l = BW'(30) - s2_bl;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_r[i] = s2_mag[i] >> sh_r;
      m_l[i] = s2_mag[i][29:0] << sh_l;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      o_v  <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      o_v  <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag[i] <= v[i][IW-1] ? (~v[i] + 1'b1) : v[i];
        s1_sgn[i] <= v[i][IW-1];
      end
      s1_side <= in_side;

      s2_mag  <= s1_mag;
      s2_sgn  <= s1_sgn;
      s2_bl   <= bl;
      s2_side <= s1_side;

      for (int i = 0; i < 3; i++) begin
        s3_m[i] <= (s2_bl > BW'(30)) ? m_r[i][29:0] : m_l[i];
      end
      s3_sgn  <= s2_sgn;
      s3_ok   <= (s2_bl != '0);
      s3_side <= s2_side;

      for (int i = 0; i < 3; i++) begin
        s4_sq[i] <= s3_m[i] * s3_m[i];
      end
      s4_m    <= s3_m;
      s4_sgn  <= s3_sgn;
      s4_ok   <= s3_ok;
      s4_side <= s3_side;

      s5_sum  <= 62'(s4_sq[0]) + 62'(s4_sq[1]) + 62'(s4_sq[2]);
      s5_m    <= s4_m;
      s5_sgn  <= s4_sgn;
      s5_ok   <= s4_ok;
      s5_side <= s4_side;

      // A zero vector yields zero components whatever the divider gave.
      for (int i = 0; i < 3; i++) begin
        if (!dv_ok) begin
          o_u[i] <= '0;
        end else if (dv_sgn[i]) begin
          o_u[i] <= ~{1'b0, dv_q[i]} + 32'd1;
        end else begin
          o_u[i] <= {1'b0, dv_q[i]};
        end
      end
      o_ok   <= dv_ok;
      o_side <= dv_side;
    end
  end

  lav_sqrt #(.PW(PW1)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s5_v),
    .rad       (s5_sum),
    .in_pay    ({s5_side, s5_ok, s5_sgn, s5_m}),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_pay   (sq_pay)
  );

  assign {sq_side, sq_ok, sq_sgn, sq_m} = sq_pay;

  lav_div #(.PW(PW2)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v),
    .dsr       (sq_root),
    .m         (sq_m),
    .in_pay    ({sq_side, sq_ok, sq_sgn}),
    .out_valid (dv_v),
    .quot      (dv_q),
    .out_pay   (dv_pay)
  );

  assign {dv_side, dv_ok, dv_sgn} = dv_pay;

  assign out_valid = o_v;
  assign u         = o_u;
  assign out_ok    = o_ok;
  assign out_side  = o_side;

endmodule

// File: src/lav_out.sv
// ----------------------------------------------------------------------------
// lav_out: row serialiser
// Holds one finished matrix and sends its three rows through an output
// register, taking the next matrix while the last row goes out.
// ----------------------------------------------------------------------------
module lav_out
  import lav_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  view_t        item,
  output logic         item_ready,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  view_t     hold_q;
  logic      hold_full;
  logic      full_next;
  row_t      row_q;
  row_t      row_next;
  logic      load;
  logic      last_row;
  row_data_t sel;

  assign load       = !m_tvalid || m_tready;
  assign last_row   = (row_q == ROW_FWD);
  assign item_ready = !hold_full || (load && last_row);

  always_comb begin
    row_next  = row_q;
    full_next = hold_full;
    if (load && hold_full) begin
      unique case (row_q)
        ROW_RIGHT: row_next = ROW_UP;
        ROW_UP:    row_next = ROW_FWD;
        ROW_FWD: begin
          row_next  = ROW_RIGHT;
          full_next = 1'b0;
        end
        default:   row_next = ROW_RIGHT;
      endcase
    end
    if (item_valid && item_ready) begin
      full_next = 1'b1;
    end
  end

  always_comb begin
    case (row_q)
      ROW_RIGHT: sel = hold_q.rows[0];
      ROW_UP:    sel = hold_q.rows[1];
      default:   sel = hold_q.rows[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_q     <= ROW_RIGHT;
      hold_full <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      row_q     <= row_next;
      hold_full <= full_next;
      if (load) begin
        m_tvalid <= hold_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold_q <= item;
    end
    if (load) begin
      m_tdata <= sel;
      m_tuser <= {hold_q.degen, row_q};
      m_tlast <= last_row;
    end
  end

`ifndef SYNTHESIS
  a_last_row : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser[1:0] == ROW_FWD)))
    else $error("tlast does not match the row index");

  a_row_step : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tuser[1:0] == $past(m_tuser[1:0]) + 2'd1))
    else $error("rows of one matrix are not sent in sequence");

  a_degen_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tuser[2] == $past(m_tuser[2]))
    else $error("degenerate flag changed within one matrix");

  a_hold_keep : assert property (@(posedge clk) disable iff (rst)
    hold_full && !(load && last_row) |=> hold_full)
    else $error("held matrix dropped before its last row was sent");
`endif

endmodule

// File: src/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix: fixed-point look-at view matrix generator
// Builds the right, up and negated forward rows of a view matrix from an eye
// point, a target point and a configured world up vector.
// ----------------------------------------------------------------------------
// Usage. Each request on the slave stream carries an eye point and a target
// point, six Q16.16 words. For every request the master stream sends three
// rows in order: right, up and negated forward, the third with tlast set.
// Each row gives a Q2.30 direction and a saturated Q16.16 translation; tuser
// holds the row index and the degenerate flag, which is set on all three rows
// when the forward or right vector has zero length.
// The world up vector sits in three APB registers (x, y, z at 0x0, 0x4, 0x8)
// and must only be written while the block is idle.
// Path: a request passes stage a, the forward normaliser, stages b and c, the
// right normaliser, stages d, g, h, i and j, the output hold register and the
// output register; its other two rows follow in order. Most of that path is
// the two normalisers, each with a 31-stage square root and a 31-stage divider.
// A request can enter every cycle while s_tready is high, but the single output
// port carries three rows per request, so the pipeline holds while the rows of
// the matrix ahead go out.
// Reset clears all valid bits and loads the up vector with (0, 1.0, 0).
// When the receiver stalls, the whole pipeline holds and s_tready drops once
// the finished matrix ahead cannot move on; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module look_at_view_matrix
  import lav_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Request stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [191:0]      s_tdata,  // eye_x, eye_y, eye_z, look_x, look_y, look_z
  // Row stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [127:0]      m_tdata,  // coef_x, coef_y, coef_z, offset
  output logic [2:0]        m_tuser,  // row_index[1:0], degenerate
  output logic              m_tlast
);

  // Round half up from Q18.46 to Q16.16 and saturate to 32 bits.
  function automatic logic [31:0] sat_q16(input logic signed [66:0] x);
    logic signed [66:0] t;
    t = (x + 67'sd536870912) >>> 30;
    if (t > 67'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (t < -67'sd2147483648) begin
      return 32'h8000_0000;
    end
    return t[31:0];
  endfunction

  // Round half up from Q4.60 to Q2.30 and clamp to plus or minus one.
  function automatic logic [31:0] clamp_q30(input logic signed [64:0] x);
    logic signed [64:0] t;
    t = (x + 65'sd536870912) >>> 30;
    if (t > 65'sd1073741824) begin
      return 32'sd1073741824;
    end else if (t < -65'sd1073741824) begin
      return -32'sd1073741824;
    end
    return t[31:0];
  endfunction

  logic signed [31:0] up_x;
  logic signed [31:0] up_y;
  logic signed [31:0] up_z;

  logic en;
  logic out_ready;

  // Stage a: eye point and eye-to-target difference.
  logic             a_v;
  logic [2:0][31:0] a_e;
  logic [2:0][32:0] a_d;

  // Forward normaliser output.
  logic             n1_v;
  logic [2:0][31:0] n1_f;
  logic             n1_ok;
  logic [2:0][31:0] n1_e;

  // Stages b and c: forward cross up.
  logic             b_v;
  logic [5:0][63:0] b_p;
  logic [2:0][31:0] b_f;
  logic [2:0][31:0] b_e;
  logic             b_ok;
  logic             c_v;
  logic [2:0][64:0] c_cr;
  logic [2:0][31:0] c_f;
  logic [2:0][31:0] c_e;
  logic             c_ok;

  // Right normaliser output.
  logic             n2_v;
  logic [2:0][31:0] n2_r;
  logic             n2_okr;
  logic [2:0][31:0] n2_f;
  logic [2:0][31:0] n2_e;
  logic             n2_okf;

  // Stage d: products for up and the dot products.
  logic             d_v;
  logic [5:0][63:0] d_rf;
  logic [2:0][63:0] d_re;
  logic [2:0][63:0] d_fe;
  logic [2:0][31:0] d_r;
  logic [2:0][31:0] d_f;
  logic [2:0][31:0] d_e;
  logic             d_deg;

  // Stage g: up vector and right and forward dot sums.
  logic             g_v;
  logic [2:0][31:0] g_u;
  logic [2:0][31:0] g_r;
  logic [2:0][31:0] g_f;
  logic [2:0][31:0] g_e;
  logic [65:0]      g_dr;
  logic [65:0]      g_df;
  logic             g_deg;

  // Stage h: up-dot-eye products and first and third offsets.
  logic             h_v;
  logic [2:0][63:0] h_ue;
  logic [2:0][31:0] h_u;
  logic [2:0][31:0] h_r;
  logic [2:0][31:0] h_f;
  logic [31:0]      h_o0;
  logic [31:0]      h_o2;
  logic             h_deg;

  // Stage i: up dot sum.
  logic             i_v;
  logic [65:0]      i_due;
  logic [2:0][31:0] i_u;
  logic [2:0][31:0] i_r;
  logic [2:0][31:0] i_f;
  logic [31:0]      i_o0;
  logic [31:0]      i_o2;
  logic             i_deg;

  // Stage j: finished matrix.
  logic             j_v;
  view_t            j_item;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_x <= 32'sd0;
      up_y <= 32'sd65536;
      up_z <= 32'sd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_UP_X: up_x <= pwdata;
        REG_UP_Y: up_y <= pwdata;
        REG_UP_Z: up_z <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_UP_X: prdata = up_x;
      REG_UP_Y: prdata = up_y;
      REG_UP_Z: prdata = up_z;
      default:  prdata = '0;
    endcase
  end

  // The whole pipeline moves together; it only holds when the finished
  // matrix at its end cannot be handed to the output stage.
  assign en       = !j_v || out_ready;
  assign s_tready = en;

  // ---------------------------------------------------------------- valids
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
      j_v <= 1'b0;
    end else if (en) begin
      a_v <= s_tvalid;
      b_v <= n1_v;
      c_v <= b_v;
      d_v <= n2_v;
      g_v <= d_v;
      h_v <= g_v;
      i_v <= h_v;
      j_v <= i_v;
    end
  end

  // ------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // Stage a: 33-bit differences cannot overflow.
      for (int k = 0; k < 3; k++) begin
        a_e[k] <= s_tdata[32*k +: 32];
        a_d[k] <= {s_tdata[32*(k+3) + 31], s_tdata[32*(k+3) +: 32]}
                - {s_tdata[32*k + 31], s_tdata[32*k +: 32]};
      end

      // Stage b: partial products of forward cross up.
      b_p[0] <= $signed(n1_f[1]) * up_z;
      b_p[1] <= $signed(n1_f[2]) * up_y;
      b_p[2] <= $signed(n1_f[2]) * up_x;
      b_p[3] <= $signed(n1_f[0]) * up_z;
      b_p[4] <= $signed(n1_f[0]) * up_y;
      b_p[5] <= $signed(n1_f[1]) * up_x;
      b_f    <= n1_f;
      b_e    <= n1_e;
      b_ok   <= n1_ok;

      // Stage c: exact cross product.
      c_cr[0] <= $signed(b_p[0]) - $signed(b_p[1]);
      c_cr[1] <= $signed(b_p[2]) - $signed(b_p[3]);
      c_cr[2] <= $signed(b_p[4]) - $signed(b_p[5]);
      c_f     <= b_f;
      c_e     <= b_e;
      c_ok    <= b_ok;

      // Stage d: right cross forward products and eye dot products.
      d_rf[0] <= $signed(n2_r[1]) * $signed(n2_f[2]);
      d_rf[1] <= $signed(n2_r[2]) * $signed(n2_f[1]);
      d_rf[2] <= $signed(n2_r[2]) * $signed(n2_f[0]);
      d_rf[3] <= $signed(n2_r[0]) * $signed(n2_f[2]);
      d_rf[4] <= $signed(n2_r[0]) * $signed(n2_f[1]);
      d_rf[5] <= $signed(n2_r[1]) * $signed(n2_f[0]);
      for (int k = 0; k < 3; k++) begin
        d_re[k] <= $signed(n2_r[k]) * $signed(n2_e[k]);
        d_fe[k] <= $signed(n2_f[k]) * $signed(n2_e[k]);
      end
      d_r   <= n2_r;
      d_f   <= n2_f;
      d_e   <= n2_e;
      d_deg <= !n2_okf || !n2_okr;

      // Stage g: up vector and dot sums.
      g_u[0] <= clamp_q30($signed(d_rf[0]) - $signed(d_rf[1]));
      g_u[1] <= clamp_q30($signed(d_rf[2]) - $signed(d_rf[3]));
      g_u[2] <= clamp_q30($signed(d_rf[4]) - $signed(d_rf[5]));
      g_dr   <= $signed(d_re[0]) + $signed(d_re[1]) + $signed(d_re[2]);
      g_df   <= $signed(d_fe[0]) + $signed(d_fe[1]) + $signed(d_fe[2]);
      g_r    <= d_r;
      g_f    <= d_f;
      g_e    <= d_e;
      g_deg  <= d_deg;

      // Stage h: right and forward offsets, up dot products.
      for (int k = 0; k < 3; k++) begin
        h_ue[k] <= $signed(g_u[k]) * $signed(g_e[k]);
      end
      h_o0  <= sat_q16(-$signed(g_dr));
      h_o2  <= sat_q16($signed(g_df));
      h_u   <= g_u;
      h_r   <= g_r;
      h_f   <= g_f;
      h_deg <= g_deg;

      // Stage i: up dot sum.
      i_due <= $signed(h_ue[0]) + $signed(h_ue[1]) + $signed(h_ue[2]);
      i_u   <= h_u;
      i_r   <= h_r;
      i_f   <= h_f;
      i_o0  <= h_o0;
      i_o2  <= h_o2;
      i_deg <= h_deg;

      // Stage j: assemble the three rows; the last row uses minus forward.
      j_item.degen      <= i_deg;
      j_item.rows[0].cx <= i_r[0];
      j_item.rows[0].cy <= i_r[1];
      j_item.rows[0].cz <= i_r[2];
      j_item.rows[0].ofs <= i_o0;
      j_item.rows[1].cx <= i_u[0];
      j_item.rows[1].cy <= i_u[1];
      j_item.rows[1].cz <= i_u[2];
      j_item.rows[1].ofs <= sat_q16(-$signed(i_due));
      j_item.rows[2].cx <= ~i_f[0] + 32'd1;
      j_item.rows[2].cy <= ~i_f[1] + 32'd1;
      j_item.rows[2].cz <= ~i_f[2] + 32'd1;
      j_item.rows[2].ofs <= i_o2;
    end
  end

  // ------------------------------------------------------------ normalisers
  lav_norm #(.IW(33), .SW(96)) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_v),
    .v         (a_d),
    .in_side   (a_e),
    .out_valid (n1_v),
    .u         (n1_f),
    .out_ok    (n1_ok),
    .out_side  (n1_e)
  );

  logic [192:0] n2_side;

  lav_norm #(.IW(65), .SW(193)) u_norm_right (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_v),
    .v         (c_cr),
    .in_side   ({c_f, c_e, c_ok}),
    .out_valid (n2_v),
    .u         (n2_r),
    .out_ok    (n2_okr),
    .out_side  (n2_side)
  );

  assign {n2_f, n2_e, n2_okf} = n2_side;

  // ---------------------------------------------------------------- output
  lav_out u_out (
    .clk        (clk),
    .rst        (rst),
    .item_valid (j_v),
    .item       (j_item),
    .item_ready (out_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
